// ===== hw/rtl/vrp_pkg.sv =====
// Shared constants for the vertex rotate and project pipeline.
package vrp_pkg;

    localparam int ZOOM       = 650;
    localparam int DIST_MIN   = 200;
    localparam int DIST_MAX   = 20000;
    localparam int DIST_W     = 15;
    localparam int PIX_FRAC   = 8;
    localparam int QUO_BITS   = 18;
    localparam int SCREEN_W   = 16;
    localparam int MAT_N      = 9;
    localparam int IDX_W      = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CENTER_W   = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PERSP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENT_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENT_Y = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DIST_RESET = 16'd600;

endpackage

// ===== hw/rtl/vrp_if.sv =====
// Request channels for vertex input and projected result output.
interface vrp_in_if #(
    parameter int COEF_WIDTH  = 16,
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [3:0]                    coef_index;
    logic signed [COEF_WIDTH-1:0]  coef_value;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, cmd, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface vrp_out_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [15:0]            screen_x;
    logic signed [15:0]            screen_y;
    logic signed [COORD_WIDTH-1:0] depth_z;
    logic                          behind_viewer;

    modport source (output valid, screen_x, screen_y, depth_z, behind_viewer, input ready);
    modport sink (input valid, screen_x, screen_y, depth_z, behind_viewer, output ready);
endinterface

// ===== hw/rtl/vrp_rotate.sv =====
// Rotation matrix store and two-stage 3x3 matrix-vector product.
module vrp_rotate
    import vrp_pkg::*;
#(
    parameter int COEF_WIDTH  = 16,
    parameter int COORD_WIDTH = 24,
    parameter int R_W         = COORD_WIDTH + 4
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          load_we,
    input  logic [IDX_W-1:0]              load_idx,
    input  logic signed [COEF_WIDTH-1:0]  load_val,
    input  logic                          pt_valid,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    input  logic signed [COORD_WIDTH-1:0] pz,
    output logic                          r_valid,
    output logic signed [R_W-1:0]         r [3]
);
    localparam int PROD_W    = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COEF_FRAC = COEF_WIDTH - 2;

    logic signed [COEF_WIDTH-1:0]  mat_reg [MAT_N];
    logic signed [PROD_W-1:0]      prod_reg [MAT_N];
    logic signed [PROD_W-1:0]      prod_next [MAT_N];
    logic signed [COORD_WIDTH-1:0] p [3];
    logic                          v1_reg;
    logic                          v2_reg;
    logic signed [SUM_W-1:0]       sum [3];
    logic signed [R_W-1:0]         r_reg [3];

    assign p[0] = px;
    assign p[1] = py;
    assign p[2] = pz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_N; i++)
                mat_reg[i] <= '0;
        end
        else if (load_we && (load_idx < IDX_W'(MAT_N)))
        begin
            mat_reg[load_idx] <= load_val;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                prod_next[i*3+k] = PROD_W'(mat_reg[i*3+k]) * PROD_W'(p[k]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sum[i] = SUM_W'(prod_reg[i*3]) + SUM_W'(prod_reg[i*3+1])
                   + SUM_W'(prod_reg[i*3+2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pt_valid;
            v2_reg <= v1_reg;
        end
    end

    // Floor shift drops the coefficient fraction bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            for (int i = 0; i < 3; i++)
                r_reg[i] <= sum[i][SUM_W-1:COEF_FRAC];
        end
    end

    assign r_valid = v2_reg;
    assign r       = r_reg;
endmodule

// ===== hw/rtl/vrp_div.sv =====
// Two-lane restoring divider, one quotient bit per pipeline stage.
module vrp_div #(
    parameter int DEN_W = 25,
    parameter int QB    = 18,
    parameter int SB_W  = 29
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DEN_W-1:0] rem_in [2],
    input  logic [QB-1:0]    low_in [2],
    input  logic [DEN_W-1:0] den_in,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [QB-1:0]    quo [2],
    output logic             rem_nz [2],
    output logic [SB_W-1:0]  sb_out
);
    logic [DEN_W-1:0] rem_a [QB+1][2];
    logic [QB-1:0]    low_a [QB+1][2];
    logic [QB-1:0]    q_a   [QB+1][2];
    logic [DEN_W-1:0] den_a [QB+1];
    logic [SB_W-1:0]  sb_a  [QB+1];
    logic             v_a   [QB+1];

    assign v_a[0]   = in_valid;
    assign den_a[0] = den_in;
    assign sb_a[0]  = sb_in;

    for (genvar l = 0; l < 2; l++)
    begin : g_in
        assign rem_a[0][l] = rem_in[l];
        assign low_a[0][l] = low_in[l];
        assign q_a[0][l]   = '0;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_a[s+1] <= 1'b0;
            else if (en)
                v_a[s+1] <= v_a[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_a[s+1] <= den_a[s];
                sb_a[s+1]  <= sb_a[s];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           take;

            assign trial = {rem_a[s][l], low_a[s][l][QB-1]};
            assign diff  = trial - {1'b0, den_a[s]};
            assign take  = (trial >= {1'b0, den_a[s]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_a[s+1][l] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    low_a[s+1][l] <= low_a[s][l] << 1;
                    q_a[s+1][l]   <= {q_a[s][l][QB-2:0], take};
                end
            end
        end
    end

    assign out_valid = v_a[QB];
    assign sb_out    = sb_a[QB];
    for (genvar l = 0; l < 2; l++)
    begin : g_out
        assign quo[l]    = q_a[QB][l];
        assign rem_nz[l] = |rem_a[QB][l];
    end
endmodule

// ===== hw/rtl/vertex_rotate_project.sv =====
// Top level: vertex rotation, perspective or parallel projection, screen clamp.
//
// Usage:
//   vtx_in carries requests: cmd LOAD writes rotation coefficient coef_index
//   (0..8, others dropped) and yields no result; cmd POINT carries a Q16.8 point
//   and yields one result on vtx_out: saturated screen x/y in pixels, the
//   saturated rotated z and a behind-viewer flag.
//   Configuration (projection mode, view distance, screen center x and y) is
//   written through cfg_we/cfg_index/cfg_data while the pipeline is empty.
// Timing:
//   One point per cycle while the output is not stalled. From input accept to
//   output valid a point passes two rotation stages, a projection setup stage,
//   a magnitude stage, 18 divider stages (one quotient bit each) and the
//   output register. The divider stage count sets the latency.
// Reset:
//   Clears the matrix to zero, perspective on, distance 600, center 0, and
//   empties the pipeline.
// Stall:
//   When a result waits and vtx_out.ready is low, the whole pipeline holds;
//   vtx_in.ready drops in the same cycle and nothing is lost or repeated.
module vertex_rotate_project
    import vrp_pkg::*;
#(
    parameter int COEF_WIDTH  = 16,
    parameter int COORD_WIDTH = 24
)(
    input  logic                   clk,
    input  logic                   rst_n,
    vrp_in_if.sink                 vtx_in,
    vrp_out_if.source              vtx_out,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    localparam int R_W    = COORD_WIDTH + 4;
    localparam int NUM_W  = R_W + 10;
    localparam int DS_W   = ((R_W > 24) ? R_W : 24) + 1;
    localparam int DEN_W  = DS_W - 1;
    localparam int HI_W   = NUM_W - QUO_BITS;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int SB_W   = COORD_WIDTH + 5;
    localparam int TW     = QUO_BITS + 3;

    // Configuration registers
    logic                 persp_reg;
    logic [15:0]          dist_reg;
    logic [CENTER_W-1:0]  cx_reg;
    logic [CENTER_W-1:0]  cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persp_reg <= 1'b1;
            dist_reg  <= DIST_RESET;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERSP:  persp_reg <= cfg_data[0];
                CFG_DIST:   dist_reg  <= cfg_data;
                CFG_CENT_X: cx_reg    <= cfg_data[CENTER_W-1:0];
                CFG_CENT_Y: cy_reg    <= cfg_data[CENTER_W-1:0];
                default:    ;
            endcase
        end
    end

    // Global advance: every stage moves when the output slot frees up.
    logic en;
    logic out_valid_reg;
    logic in_acc;

    assign en           = !out_valid_reg || vtx_out.ready;
    assign vtx_in.ready = en;
    assign in_acc       = vtx_in.valid && en;

    // Rotation: stages 1 and 2
    logic                  r_valid;
    logic signed [R_W-1:0] r [3];

    vrp_rotate #(
        .COEF_WIDTH  (COEF_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .R_W         (R_W)
    ) u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .load_we  (in_acc && (vtx_in.cmd == CMD_LOAD)),
        .load_idx (vtx_in.coef_index),
        .load_val (vtx_in.coef_value),
        .pt_valid (in_acc && (vtx_in.cmd == CMD_POINT)),
        .px       (vtx_in.point_x),
        .py       (vtx_in.point_y),
        .pz       (vtx_in.point_z),
        .r_valid  (r_valid),
        .r        (r)
    );

    // Stage 3: numerators, denominator, depth clamp
    logic [DIST_W-1:0]             dcl;
    logic signed [DS_W-1:0]        d_ext;
    logic signed [DS_W-1:0]        den_s;
    logic signed [NUM_W-1:0]       n_next [2];
    logic [DEN_W-1:0]              den_next;
    logic                          behind_next;
    logic signed [COORD_WIDTH-1:0] dz_next;
    logic                          dz_fits;

    always_comb
    begin
        if (dist_reg < 16'(DIST_MIN))
            dcl = DIST_W'(DIST_MIN);
        else if (dist_reg > 16'(DIST_MAX))
            dcl = DIST_W'(DIST_MAX);
        else
            dcl = dist_reg[DIST_W-1:0];
    end

    assign d_ext = DS_W'({dcl, {PIX_FRAC{1'b0}}});
    assign den_s = DS_W'(r[2]) + d_ext;

    always_comb
    begin
        behind_next = 1'b0;
        den_next    = DEN_W'(1 << PIX_FRAC);
        for (int l = 0; l < 2; l++)
            n_next[l] = NUM_W'(r[l]);
        if (persp_reg)
        begin
            for (int l = 0; l < 2; l++)
                n_next[l] = NUM_W'(r[l]) * $signed(NUM_W'(ZOOM));
            if (den_s[DS_W-1] || (den_s == '0))
            begin
                behind_next = 1'b1;
                den_next    = DEN_W'(1);
            end
            else
            begin
                den_next = den_s[DEN_W-1:0];
            end
        end
    end

    // Rotated z fits when the bits above the output sign all match it.
    assign dz_fits = (&r[2][R_W-1:COORD_WIDTH-1]) || !(|r[2][R_W-1:COORD_WIDTH-1]);

    always_comb
    begin
        if (dz_fits)
            dz_next = r[2][COORD_WIDTH-1:0];
        else if (r[2][R_W-1])
            dz_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            dz_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end

    logic                          s3_v_reg;
    logic signed [NUM_W-1:0]       s3_n_reg [2];
    logic [DEN_W-1:0]              s3_den_reg;
    logic                          s3_behind_reg;
    logic signed [COORD_WIDTH-1:0] s3_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_n_reg      <= n_next;
            s3_den_reg    <= den_next;
            s3_behind_reg <= behind_next;
            s3_dz_reg     <= dz_next;
        end
    end

    // Stage 4: magnitude, overflow check, divider seed
    logic [NUM_W-1:0] mag [2];
    logic             ovf_next [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag[l]      = s3_n_reg[l][NUM_W-1] ? NUM_W'(-s3_n_reg[l]) : NUM_W'(s3_n_reg[l]);
            ovf_next[l] = CMP_W'(mag[l][NUM_W-1:QUO_BITS]) >= CMP_W'(s3_den_reg);
        end
    end

    logic             s4_v_reg;
    logic [DEN_W-1:0] s4_rem_reg [2];
    logic [QUO_BITS-1:0] s4_low_reg [2];
    logic [DEN_W-1:0] s4_den_reg;
    logic [SB_W-1:0]  s4_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                s4_rem_reg[l] <= DEN_W'(mag[l][NUM_W-1:QUO_BITS]);
                s4_low_reg[l] <= mag[l][QUO_BITS-1:0];
            end
            s4_den_reg <= s3_den_reg;
            s4_sb_reg  <= {s3_n_reg[0][NUM_W-1], s3_n_reg[1][NUM_W-1],
                           ovf_next[0], ovf_next[1], s3_behind_reg, s3_dz_reg};
        end
    end

    // Divider pipeline
    logic                d_valid;
    logic [QUO_BITS-1:0] quo [2];
    logic                rnz [2];
    logic [SB_W-1:0]     sb;

    vrp_div #(
        .DEN_W (DEN_W),
        .QB    (QUO_BITS),
        .SB_W  (SB_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .rem_in    (s4_rem_reg),
        .low_in    (s4_low_reg),
        .den_in    (s4_den_reg),
        .sb_in     (s4_sb_reg),
        .out_valid (d_valid),
        .quo       (quo),
        .rem_nz    (rnz),
        .sb_out    (sb)
    );

    // Final stage: floor quotient, add center, truncate toward zero, saturate; zero when behind the viewer
    logic                 sgn [2];
    logic                 ovf [2];
    logic [CENTER_W-1:0]  cen [2];
    logic signed [TW-1:0] qe [2];
    logic signed [TW-1:0] fl [2];
    logic signed [TW-1:0] t [2];
    logic signed [SCREEN_W-1:0] scr [2];
    logic                 behind_d;

    assign sgn[0]   = sb[SB_W-1];
    assign sgn[1]   = sb[SB_W-2];
    assign ovf[0]   = sb[SB_W-3];
    assign ovf[1]   = sb[SB_W-4];
    assign behind_d = sb[COORD_WIDTH];
    assign cen[0]   = cx_reg;
    assign cen[1]   = cy_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            qe[l] = TW'(quo[l]);
            fl[l] = sgn[l] ? (-qe[l] - TW'(rnz[l])) : qe[l];
            t[l]  = fl[l] + TW'(cen[l]);
            if (t[l][TW-1] && rnz[l])
                t[l] = t[l] + TW'(1);
            if (behind_d)
                scr[l] = '0;
            else if (ovf[l])
                scr[l] = sgn[l] ? {1'b1, {(SCREEN_W-1){1'b0}}}
                                : {1'b0, {(SCREEN_W-1){1'b1}}};
            else if ((&t[l][TW-1:SCREEN_W-1]) || !(|t[l][TW-1:SCREEN_W-1]))
                scr[l] = t[l][SCREEN_W-1:0];
            else
                scr[l] = t[l][TW-1] ? {1'b1, {(SCREEN_W-1){1'b0}}}
                                    : {1'b0, {(SCREEN_W-1){1'b1}}};
        end
    end

    logic signed [SCREEN_W-1:0]    sx_reg;
    logic signed [SCREEN_W-1:0]    sy_reg;
    logic signed [COORD_WIDTH-1:0] dz_reg;
    logic                          behind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg     <= scr[0];
            sy_reg     <= scr[1];
            dz_reg     <= sb[COORD_WIDTH-1:0];
            behind_reg <= behind_d;
        end
    end

    assign vtx_out.valid         = out_valid_reg;
    assign vtx_out.screen_x      = sx_reg;
    assign vtx_out.screen_y      = sy_reg;
    assign vtx_out.depth_z       = dz_reg;
    assign vtx_out.behind_viewer = behind_reg;

`ifndef SYNTH
    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && behind_reg) |-> (sx_reg == '0) && (sy_reg == '0))
        else $error("behind-viewer result has nonzero screen coordinates");

    a_behind_persp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && behind_reg) |-> persp_reg)
        else $error("behind-viewer flag raised in parallel mode");

    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_in.ready == (!out_valid_reg || vtx_out.ready))
        else $error("input ready does not follow output slot state");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !vtx_out.ready) |=> $stable(s4_v_reg) && $stable(s3_v_reg))
        else $error("inner stage moved while output stalled");
`endif
endmodule

// ===== tb/vertex_rotate_project_test.sv =====
// Testbench for the vertex rotate and project stage: directed and random requests.
`timescale 1ns / 100ps

module vertex_rotate_project_test;
    import vrp_pkg::*;

    localparam int CW = 16;
    localparam int PW = 24;
    localparam int LATENCY = 23;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0]   screen_x;
        logic signed [15:0]   screen_y;
        logic signed [PW-1:0] depth_z;
        logic                 behind_viewer;
    } projection_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vrp_in_if  #(.COEF_WIDTH(CW), .COORD_WIDTH(PW)) vtx_in ();
    vrp_out_if #(.COORD_WIDTH(PW)) vtx_out ();

    vertex_rotate_project #(.COEF_WIDTH(CW), .COORD_WIDTH(PW)) DUT (
        .clk(clk), .rst_n(rst_n), .vtx_in(vtx_in), .vtx_out(vtx_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the block's state and registers.
    logic signed [CW-1:0] shadow_matrix [MAT_N];
    logic                 shadow_persp;
    logic [15:0]          shadow_dist;
    logic [CENTER_W-1:0]  shadow_cx;
    logic [CENTER_W-1:0]  shadow_cy;

    projection_t pending_projections [$];
    int error_count;
    int points_checked;
    int behind_count;
    int idle_cycles;
    int send_idle_pct;
    int stall_pct;

    always #5 clk = ~clk;

    // Predict one point request against the shadow matrix and registers.
    function automatic projection_t project_point(logic signed [PW-1:0] px,
                                                  logic signed [PW-1:0] py,
                                                  logic signed [PW-1:0] pz);
        projection_t res;
        longint rot [3];
        longint acc, d, den, sx, sy, cmax;
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = longint'(shadow_matrix[i*3]) * longint'(px)
                    + longint'(shadow_matrix[i*3+1]) * longint'(py)
                    + longint'(shadow_matrix[i*3+2]) * longint'(pz);
                rot[i] = acc >>> (CW - 2);   // arithmetic shift floors
            end
            res.behind_viewer = 1'b0;
            if (shadow_persp)
            begin
                d = longint'(shadow_dist);
                if (d < DIST_MIN) d = DIST_MIN;
                if (d > DIST_MAX) d = DIST_MAX;
                den = rot[2] + d * 256;
                if (den <= 0)
                begin
                    res.behind_viewer = 1'b1;
                    sx = 0;
                    sy = 0;
                end
                else
                begin
                    sx = (ZOOM * rot[0] + longint'(shadow_cx) * den) / den;
                    sy = (ZOOM * rot[1] + longint'(shadow_cy) * den) / den;
                end
            end
            else
            begin
                sx = (rot[0] + longint'(shadow_cx) * 256) / 256;
                sy = (rot[1] + longint'(shadow_cy) * 256) / 256;
            end
            if (sx > 32767) sx = 32767;
            if (sx < -32768) sx = -32768;
            if (sy > 32767) sy = 32767;
            if (sy < -32768) sy = -32768;
            cmax = (longint'(1) <<< (PW - 1)) - 1;
            if (rot[2] > cmax) rot[2] = cmax;
            if (rot[2] < -cmax - 1) rot[2] = -cmax - 1;
            res.screen_x = sx[15:0];
            res.screen_y = sy[15:0];
            res.depth_z  = rot[2][PW-1:0];
            return res;
        end
    endfunction

    // Send one request; hold valid until accepted, then update the shadow state.
    task automatic send_request(logic cmd, logic [3:0] idx, logic signed [CW-1:0] coef,
                                logic signed [PW-1:0] px, logic signed [PW-1:0] py,
                                logic signed [PW-1:0] pz);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                vtx_in.valid <= 1'b0;
                @(negedge clk);
            end
            vtx_in.valid      <= 1'b1;
            vtx_in.cmd        <= cmd;
            vtx_in.coef_index <= idx;
            vtx_in.coef_value <= coef;
            vtx_in.point_x    <= px;
            vtx_in.point_y    <= py;
            vtx_in.point_z    <= pz;
            @(posedge clk);
            while (!vtx_in.ready) @(posedge clk);
            if (cmd == CMD_LOAD)
            begin
                if (idx < MAT_N) shadow_matrix[idx] = coef;
            end
            else
                pending_projections.insert(pending_projections.size(),
                                           project_point(px, py, pz));
            @(negedge clk);
        end
    endtask

    task automatic load_coef(int idx, logic signed [CW-1:0] coef);
        send_request(CMD_LOAD, idx[3:0], coef, PW'($urandom), PW'($urandom), PW'($urandom));
    endtask

    task automatic send_point(logic signed [PW-1:0] px, logic signed [PW-1:0] py,
                              logic signed [PW-1:0] pz);
        send_request(CMD_POINT, 4'($urandom), CW'($urandom), px, py, pz);
    endtask

    // Drop valid, wait for the pipeline to drain, then settle past its latency.
    task automatic drain_pipeline();
        begin
            vtx_in.valid <= 1'b0;
            while (pending_projections.size() != 0) @(negedge clk);
            repeat (LATENCY + 5) @(negedge clk);
        end
    endtask

    // Write one register while idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        begin
            drain_pipeline();
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (idx)
                CFG_PERSP:  shadow_persp = value[0];
                CFG_DIST:   shadow_dist  = value;
                CFG_CENT_X: shadow_cx    = value[CENTER_W-1:0];
                CFG_CENT_Y: shadow_cy    = value[CENTER_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        begin
            send_idle_pct = send_pct;
            stall_pct     = recv_pct;
        end
    endtask

    // Load a random matrix: mostly rotation-like magnitudes, sometimes full range.
    task automatic load_random_matrix();
        begin
            for (int i = 0; i < MAT_N; i++)
                if ($urandom_range(3) == 0)
                    load_coef(i, CW'($urandom));
                else
                    load_coef(i, $signed(16'($urandom_range(32768))) - 16'sd16384);
        end
    endtask

    function automatic logic signed [PW-1:0] random_coord();
        case ($urandom_range(3))
            0:       return PW'($urandom);
            1:       return $signed(PW'($urandom_range(8192))) - 24'sd4096;
            default: return $signed(PW'($urandom_range(262144))) - 24'sd131072;
        endcase
    endfunction

    // Extremes of fields, identity and full-scale matrices, ignored index loads.
    task automatic test_directed();
        begin
            send_point(24'sd256, -24'sd256, 24'sd512);     // all-zero matrix
            load_coef(0, 16'sd16384);
            load_coef(4, 16'sd16384);
            load_coef(8, 16'sd16384);
            load_coef(9, 16'sh7FFF);                        // out of range, dropped
            load_coef(15, -16'sd32768);                     // out of range, dropped
            send_point(24'sd25600, 24'sd12800, 24'sd0);
            send_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
            send_point(24'sh800000, 24'sh7FFFFF, 24'sh800000); // behind the viewer
            send_point(24'sd100, -24'sd100, -24'sd153600);    // z + d exactly zero
            send_point(24'sd100, -24'sd100, -24'sd153599);
            load_coef(1, -16'sd32768);
            load_coef(2, 16'sh7FFF);
            load_coef(6, 16'sh7FFF);
            load_coef(7, 16'sh7FFF);
            send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF); // depth saturates high
            send_point(24'sh800000, 24'sh800000, 24'sh800000);
            send_point(-24'sd1, -24'sd1, -24'sd1);              // floor rounding
            send_point(24'sd1, 24'sd1, 24'sd1);
        end
    endtask

    task automatic test_register_extremes();
        begin
            write_register(CFG_DIST, 16'd0);
            write_register(CFG_CENT_X, 16'd4095);
            write_register(CFG_CENT_Y, 16'hFFFF);
            for (int i = 0; i < 6; i++) send_point(random_coord(), random_coord(), random_coord());
            write_register(CFG_DIST, 16'hFFFF);
            write_register(CFG_CENT_Y, 16'd0);
            for (int i = 0; i < 6; i++) send_point(random_coord(), random_coord(), random_coord());
            write_register(CFG_PERSP, 16'd0);
            for (int i = 0; i < 6; i++) send_point(random_coord(), random_coord(), random_coord());
            write_register(CFG_PERSP, 16'hFFFE);            // bit 0 clear: parallel
            write_register(CFG_CENT_X, 16'd0);
            send_point(24'sh800000, 24'sh7FFFFF, 24'sd0);
        end
    endtask

    // Random phases under each idling mix and register setting.
    task automatic test_random_stream(int send_pct, int recv_pct, int count);
        begin
            write_register(CFG_PERSP, 16'($urandom));
            write_register(CFG_DIST, ($urandom_range(3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(150, 2000)));
            write_register(CFG_CENT_X, 16'($urandom));
            write_register(CFG_CENT_Y, 16'($urandom));
            set_idling(send_pct, recv_pct);
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(19) == 0)
                    load_random_matrix();
                else if ($urandom_range(29) == 0)
                    load_coef($urandom_range(9, 15), CW'($urandom));
                else
                    send_point(random_coord(), random_coord(), random_coord());
            end
        end
    endtask

    // Drive ready and check each accepted result against the oldest prediction.
    always @(negedge clk)
        vtx_out.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        projection_t exp_res;
        if (rst_n && vtx_out.valid && vtx_out.ready)
        begin
            if (pending_projections.size() == 0)
            begin
                $error("result with no pending prediction");
                error_count++;
            end
            else
            begin
                exp_res = pending_projections.pop_front();
                points_checked++;
                if (exp_res.behind_viewer) behind_count++;
                if (vtx_out.screen_x !== exp_res.screen_x)
                begin
                    $error("screen_x expected %0d got %0d", exp_res.screen_x, vtx_out.screen_x);
                    error_count++;
                end
                if (vtx_out.screen_y !== exp_res.screen_y)
                begin
                    $error("screen_y expected %0d got %0d", exp_res.screen_y, vtx_out.screen_y);
                    error_count++;
                end
                if (vtx_out.depth_z !== exp_res.depth_z)
                begin
                    $error("depth_z expected %0d got %0d", exp_res.depth_z, vtx_out.depth_z);
                    error_count++;
                end
                if (vtx_out.behind_viewer !== exp_res.behind_viewer)
                begin
                    $error("behind_viewer expected %0d got %0d",
                           exp_res.behind_viewer, vtx_out.behind_viewer);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request accepted on either side and no register write.
    always @(posedge clk)
    begin
        if ((vtx_in.valid && vtx_in.ready) || (vtx_out.valid && vtx_out.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        vtx_in.valid = 1'b0;
        vtx_in.cmd = CMD_LOAD;
        vtx_in.coef_index = '0;
        vtx_in.coef_value = '0;
        vtx_in.point_x = '0;
        vtx_in.point_y = '0;
        vtx_in.point_z = '0;
        vtx_out.ready = 1'b0;
        error_count = 0;
        points_checked = 0;
        behind_count = 0;
        idle_cycles = 0;
        set_idling(0, 0);
        for (int i = 0; i < MAT_N; i++) shadow_matrix[i] = '0;
        shadow_persp = 1'b1;
        shadow_dist  = DIST_RESET;
        shadow_cx    = '0;
        shadow_cy    = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_register_extremes();
        test_random_stream(0, 0, 180);
        test_random_stream(52, 0, 180);
        test_random_stream(0, 52, 180);
        test_random_stream(17, 17, 180);
        set_idling(0, 0);
        drain_pipeline();

        $display("covered %0d projected points, %0d behind the viewer, across four idling mixes",
                 points_checked, behind_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
